/* rtl/lade_pkg.sv */
package lade_pkg;

    localparam int SAMPLE_W = 24;
    localparam int POS_W    = 24;
    localparam int FRAC_W   = 15;
    localparam int LEN_W    = 21;
    localparam int LVL_W    = 16;
    localparam int RATE_W   = 18;
    localparam int ENV_W    = FRAC_W + 3;
    localparam int QUO_W    = FRAC_W + 1;
    localparam int NUM_W    = LEN_W + QUO_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = LEN_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [LVL_W-1:0] ONE_LVL = LVL_W'(1) << FRAC_W;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FMODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RATE    = 3'd5;

    typedef struct packed {
        logic [LEN_W-1:0]  attack;
        logic [LEN_W-1:0]  decay;
        logic [LVL_W-1:0]  sustain;
        logic [LVL_W-1:0]  depth;
        logic              fmode;
        logic [RATE_W-1:0] rate;
    } lade_cfg_t;

    // classified word handed from front to back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       fmode;
        logic                       shaped;
        logic                       neg;
        logic signed [ENV_W-1:0]    base;
        logic [NUM_W-1:0]           num;
        logic [LEN_W-1:0]           den;
        logic [RATE_W-1:0]          rate;
    } lade_item_t;

    typedef struct packed {
        logic                  full;
        logic                  empty;
        logic [FIFO_AW:0]      count;
    } lade_fifo_stat_t;

endpackage

/* rtl/lade_front.sv */
module lade_front (
    input  lade_pkg::lade_cfg_t                 cfg,
    input  logic signed [lade_pkg::SAMPLE_W-1:0] sample,
    input  logic [lade_pkg::POS_W-1:0]          position,
    input  logic                                last_in_block,
    output lade_pkg::lade_item_t                item
);

    logic [lade_pkg::LVL_W-1:0]   sus;
    logic [lade_pkg::LVL_W-1:0]   dep;
    logic [lade_pkg::LEN_W:0]     att_dec;
    logic                         in_att;
    logic                         in_dec;
    logic [lade_pkg::LEN_W-1:0]   pa;
    logic [lade_pkg::LVL_W-1:0]   mul_a;
    logic [lade_pkg::LEN_W-1:0]   mul_b;
    logic [lade_pkg::NUM_W-1:0]   prod;

    always_comb begin
        sus = (cfg.sustain > lade_pkg::ONE_LVL) ? lade_pkg::ONE_LVL : cfg.sustain;
        dep = (cfg.depth > lade_pkg::ONE_LVL) ? lade_pkg::ONE_LVL : cfg.depth;
        att_dec = {1'b0, cfg.attack} + {1'b0, cfg.decay};
        in_att = position < {{(lade_pkg::POS_W-lade_pkg::LEN_W){1'b0}}, cfg.attack};
        in_dec = !in_att &&
                 (position < {{(lade_pkg::POS_W-lade_pkg::LEN_W-1){1'b0}}, att_dec});
        // only used in decay, where position - attack < decay
        pa = lade_pkg::LEN_W'(position[lade_pkg::LEN_W:0] - {1'b0, cfg.attack});
        mul_a = in_att ? dep : lade_pkg::LVL_W'(lade_pkg::ONE_LVL - sus);
        mul_b = in_att ? position[lade_pkg::LEN_W-1:0] : pa;
        prod = lade_pkg::NUM_W'(mul_a) * lade_pkg::NUM_W'(mul_b);

        item.sample = sample;
        item.last   = last_in_block;
        item.fmode  = cfg.fmode;
        item.shaped = in_att || in_dec;
        item.neg    = in_dec;
        item.rate   = (cfg.rate == '0) ? lade_pkg::RATE_W'(1) : cfg.rate;
        if (in_att) begin
            item.den = cfg.attack;
            if (cfg.fmode) begin
                item.base = -lade_pkg::ENV_W'(lade_pkg::ONE_LVL);
                item.num  = {position[lade_pkg::LEN_W-1:0], {lade_pkg::QUO_W{1'b0}}};
            end else begin
                item.base = lade_pkg::ENV_W'(lade_pkg::ONE_LVL - dep);
                item.num  = prod;
            end
        end else if (in_dec) begin
            item.den  = cfg.decay;
            item.base = lade_pkg::ENV_W'(lade_pkg::ONE_LVL);
            item.num  = prod;
        end else begin
            item.den  = lade_pkg::LEN_W'(1);
            item.base = lade_pkg::ENV_W'(sus);
            item.num  = '0;
        end
    end

endmodule

/* rtl/lade_fifo.sv */
module lade_fifo (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  lade_pkg::lade_item_t      push_item,
    input  logic                      pop,
    output lade_pkg::lade_item_t      pop_item,
    output lade_pkg::lade_fifo_stat_t stat
);

    lade_pkg::lade_item_t            mem_reg [lade_pkg::FIFO_DEPTH];
    logic [lade_pkg::FIFO_AW-1:0]    wr_reg, wr_next;
    logic [lade_pkg::FIFO_AW-1:0]    rd_reg, rd_next;
    logic [lade_pkg::FIFO_AW:0]      cnt_reg, cnt_next;

    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
        stat.count = cnt_reg;
        stat.full  = cnt_reg == (lade_pkg::FIFO_AW+1)'(lade_pkg::FIFO_DEPTH);
        stat.empty = cnt_reg == '0;
        pop_item   = mem_reg[rd_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

/* rtl/lade_back.sv */
module lade_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    input  lade_pkg::lade_item_t                 in_item,
    output logic                                 in_pop,
    output logic                                 out_valid,
    output logic signed [lade_pkg::SAMPLE_W-1:0] out_value,
    output logic                                 out_last,
    input  logic                                 out_ready
);

    localparam int QW   = lade_pkg::QUO_W;
    localparam int LW   = lade_pkg::LEN_W;
    localparam int RW   = lade_pkg::RATE_W;
    localparam int SW   = lade_pkg::SAMPLE_W;
    localparam int EW   = lade_pkg::ENV_W;
    localparam int PW   = SW + EW;
    localparam int TW   = PW - lade_pkg::FRAC_W;
    localparam int AW   = SW + 2;

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 last;
        logic                 fmode;
        logic                 shaped;
        logic                 neg;
        logic signed [EW-1:0] envq;
        logic [QW-1:0]        mag;
        logic [RW-1:0]        rate;
    } env_t;

    logic                 adv;
    logic                 v1_reg [QW+1];
    lade_pkg::lade_item_t it1_reg [QW+1];
    logic [LW-1:0]        rem1_reg [QW+1];
    logic [QW-1:0]        q1_reg [QW+1];
    logic [LW-1:0]        rem1_next [QW+1];
    logic [QW-1:0]        q1_next [QW+1];

    logic                 v2_reg [QW+1];
    env_t                 e2_reg [QW+1];
    logic [RW-1:0]        rem2_reg [QW+1];
    logic [QW-1:0]        q2_reg [QW+1];
    logic [RW-1:0]        rem2_next [QW+1];
    logic [QW-1:0]        q2_next [QW+1];
    env_t                 e_next;

    logic                       vm_reg;
    logic signed [PW-1:0]       prod_reg, prod_next;
    logic signed [AW-1:0]       fsum_reg, fsum_next;
    logic                       fm_reg, last_m_reg;

    logic                       vo_reg;
    logic signed [SW-1:0]       val_reg, val_next;
    logic                       last_o_reg;

    logic signed [PW-1:0]       adj;
    logic signed [TW-1:0]       amp;

    localparam logic signed [TW-1:0] SMAX_T = TW'((64'sd1 <<< (SW-1)) - 1);
    localparam logic signed [TW-1:0] SMIN_T = TW'(-(64'sd1 <<< (SW-1)));
    localparam logic signed [AW-1:0] SMAX_A = AW'((64'sd1 <<< (SW-1)) - 1);
    localparam logic signed [AW-1:0] SMIN_A = AW'(-(64'sd1 <<< (SW-1)));

    assign adv    = !vo_reg || out_ready;
    assign in_pop = adv && in_valid;

    // two restoring divisions, one quotient bit per stage; then product and clamp
    always_comb begin
        logic [LW:0] c1;
        logic [RW:0] c2;
        rem1_next[0] = in_item.num[lade_pkg::NUM_W-1:QW];
        q1_next[0]   = '0;
        for (int k = 1; k <= QW; k++) begin
            c1 = {rem1_reg[k-1], it1_reg[k-1].num[QW-k]};
            if (c1 >= {1'b0, it1_reg[k-1].den}) begin
                rem1_next[k] = LW'(c1 - {1'b0, it1_reg[k-1].den});
                q1_next[k]   = q1_reg[k-1] | (QW'(1) << (QW-k));
            end else begin
                rem1_next[k] = LW'(c1);
                q1_next[k]   = q1_reg[k-1];
            end
        end

        e_next.sample = it1_reg[QW].sample;
        e_next.last   = it1_reg[QW].last;
        e_next.fmode  = it1_reg[QW].fmode;
        e_next.shaped = it1_reg[QW].shaped;
        e_next.rate   = it1_reg[QW].rate;
        if (it1_reg[QW].neg) begin
            e_next.envq = it1_reg[QW].base - EW'(q1_reg[QW]);
        end else begin
            e_next.envq = it1_reg[QW].base + EW'(q1_reg[QW]);
        end
        e_next.neg = e_next.envq < 0;
        e_next.mag = e_next.neg ? QW'(-e_next.envq) : QW'(e_next.envq);

        rem2_next[0] = '0;
        q2_next[0]   = '0;
        for (int k = 1; k <= QW; k++) begin
            c2 = {rem2_reg[k-1], e2_reg[k-1].mag[QW-k]};
            if (c2 >= {1'b0, e2_reg[k-1].rate}) begin
                rem2_next[k] = RW'(c2 - {1'b0, e2_reg[k-1].rate});
                q2_next[k]   = q2_reg[k-1] | (QW'(1) << (QW-k));
            end else begin
                rem2_next[k] = RW'(c2);
                q2_next[k]   = q2_reg[k-1];
            end
        end

        prod_next = PW'(e2_reg[QW].sample) * PW'(e2_reg[QW].envq);
        if (!e2_reg[QW].shaped) begin
            fsum_next = AW'(e2_reg[QW].sample);
        end else if (e2_reg[QW].neg) begin
            fsum_next = AW'(e2_reg[QW].sample) - AW'(q2_reg[QW]);
        end else begin
            fsum_next = AW'(e2_reg[QW].sample) + AW'(q2_reg[QW]);
        end

        // truncate toward zero
        adj = prod_reg + ((prod_reg < 0) ? PW'((1 << lade_pkg::FRAC_W) - 1) : PW'(0));
        amp = TW'(adj >>> lade_pkg::FRAC_W);
        if (fm_reg) begin
            if (fsum_reg > SMAX_A)      val_next = SW'(SMAX_A);
            else if (fsum_reg < SMIN_A) val_next = SW'(SMIN_A);
            else                        val_next = SW'(fsum_reg);
        end else begin
            if (amp > SMAX_T)           val_next = SW'(SMAX_T);
            else if (amp < SMIN_T)      val_next = SW'(SMIN_T);
            else                        val_next = SW'(amp);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QW; k++) begin
                v1_reg[k] <= 1'b0;
                v2_reg[k] <= 1'b0;
            end
            vm_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (adv) begin
            v1_reg[0] <= in_valid;
            v2_reg[0] <= v1_reg[QW];
            for (int k = 1; k <= QW; k++) begin
                v1_reg[k] <= v1_reg[k-1];
                v2_reg[k] <= v2_reg[k-1];
            end
            vm_reg <= v2_reg[QW];
            vo_reg <= vm_reg;
        end
        if (adv) begin
            it1_reg[0]  <= in_item;
            rem1_reg[0] <= rem1_next[0];
            q1_reg[0]   <= q1_next[0];
            e2_reg[0]   <= e_next;
            rem2_reg[0] <= rem2_next[0];
            q2_reg[0]   <= q2_next[0];
            for (int k = 1; k <= QW; k++) begin
                it1_reg[k]  <= it1_reg[k-1];
                rem1_reg[k] <= rem1_next[k];
                q1_reg[k]   <= q1_next[k];
                e2_reg[k]   <= e2_reg[k-1];
                rem2_reg[k] <= rem2_next[k];
                q2_reg[k]   <= q2_next[k];
            end
            prod_reg   <= prod_next;
            fsum_reg   <= fsum_next;
            fm_reg     <= e2_reg[QW].fmode;
            last_m_reg <= e2_reg[QW].last;
            val_reg    <= val_next;
            last_o_reg <= last_m_reg;
        end
    end

    assign out_valid = vo_reg;
    assign out_value = val_reg;
    assign out_last  = last_o_reg;

endmodule

/* rtl/linear_ads_envelope_apply.sv */
// Linear attack/decay/sustain envelope applied to one signed 24-bit sample per
// word, at the position carried with it. One word per clock is sustained
// while m_tready is high. Words pass the queue, two restoring dividers of a load
// register and 16 quotient stages each (envelope slope, then the frequency-mode
// division by sample rate), a multiply stage and the output register. A 4-word
// queue before the dividers lets the input keep accepting while an output word
// waits, until the queue is full. Configuration is written through cfg_wr_en/
// cfg_wr_idx/cfg_wr_data while idle; the user must ensure it, not the block.
module linear_ads_envelope_apply (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lade_pkg::CFG_IDX_W-1:0]     cfg_wr_idx,
    input  logic [lade_pkg::CFG_DAT_W-1:0]     cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [47:0]                        s_tdata,   // sample, position
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [23:0]                        m_tdata,   // value
    output logic                               m_tlast
);

    lade_pkg::lade_cfg_t       cfg_reg;
    lade_pkg::lade_item_t      front_item;
    lade_pkg::lade_item_t      back_item;
    lade_pkg::lade_fifo_stat_t fifo_stat;
    logic                      push;
    logic                      pop;
    logic signed [lade_pkg::SAMPLE_W-1:0] out_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.attack  <= '0;
            cfg_reg.decay   <= '0;
            cfg_reg.sustain <= lade_pkg::ONE_LVL;
            cfg_reg.depth   <= '0;
            cfg_reg.fmode   <= 1'b0;
            cfg_reg.rate    <= lade_pkg::RATE_W'(48000);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_idx)
                lade_pkg::REG_ATTACK:  cfg_reg.attack  <= cfg_wr_data;
                lade_pkg::REG_DECAY:   cfg_reg.decay   <= cfg_wr_data;
                lade_pkg::REG_SUSTAIN: cfg_reg.sustain <= cfg_wr_data[lade_pkg::LVL_W-1:0];
                lade_pkg::REG_DEPTH:   cfg_reg.depth   <= cfg_wr_data[lade_pkg::LVL_W-1:0];
                lade_pkg::REG_FMODE:   cfg_reg.fmode   <= cfg_wr_data[0];
                lade_pkg::REG_RATE:    cfg_reg.rate    <= cfg_wr_data[lade_pkg::RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !fifo_stat.full;
    assign push     = s_tvalid && s_tready;

    lade_front u_front (
        .cfg           (cfg_reg),
        .sample        (s_tdata[23:0]),
        .position      (s_tdata[47:24]),
        .last_in_block (s_tlast),
        .item          (front_item)
    );

    lade_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .pop_item  (back_item),
        .stat      (fifo_stat)
    );

    lade_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (!fifo_stat.empty),
        .in_item   (back_item),
        .in_pop    (pop),
        .out_valid (m_tvalid),
        .out_value (out_value),
        .out_last  (m_tlast),
        .out_ready (m_tready)
    );

    assign m_tdata = out_value;

`ifndef SYNTH
    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_stat.count <= (lade_pkg::FIFO_AW+1)'(lade_pkg::FIFO_DEPTH))
        else $error("queue count above depth");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !fifo_stat.empty)
        else $error("pop from empty queue");
    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> fifo_stat.count == $past(fifo_stat.count) + 1'b1)
        else $error("queue count lost a word");
`endif

endmodule
